// File: design/les_pkg.sv
// ----------------------------------------------------------------------------
// les_pkg
// types and constants shared by the led effect sequencer modules
// ----------------------------------------------------------------------------
package les_pkg;

    // effect codes, same encoding as the effect_mode register
    typedef enum logic [1:0] {
        MODE_OFF     = 2'd0,
        MODE_STATIC  = 2'd1,
        MODE_BLINK   = 2'd2,
        MODE_BREATHE = 2'd3
    } les_mode_t;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_MODE       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EFFECT_COLOR      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BLINK_LIMIT       = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_BRIGHTNESS = 8'd3;

    localparam logic [31:0] BLINK_PERIOD_MS     = 32'd100;
    localparam logic [31:0] BREATHE_PERIOD_MS   = 32'd20;
    localparam logic [6:0]  RAMP_TOP            = 7'd100;
    localparam logic [7:0]  BRIGHTNESS_AT_RESET = 8'd50;

    typedef struct packed {
        les_mode_t   mode;
        logic [31:0] last_step_time;
        logic        blink_on;
        logic [7:0]  blinks_done;
        logic [6:0]  ramp_level;
        logic        ramp_rising;
        logic [7:0]  brightness_now;
        logic [23:0] color_now;
    } les_state_t;

    typedef struct packed {
        logic [23:0] color;
        logic [7:0]  brightness;
        logic        refresh;
    } les_result_t;

endpackage

// File: design/les_ifs.sv
// ----------------------------------------------------------------------------
// les channel interfaces
// valid/ready channels for updates, pixel results and register writes
// ----------------------------------------------------------------------------
interface les_update_if;
    logic        valid;
    logic        ready;
    logic [31:0] now_ms;

    modport source (output valid, output now_ms, input ready);
    modport sink   (input valid, input now_ms, output ready);
endinterface

interface les_pixel_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;
    logic [7:0]  pixel_brightness;
    logic        refresh;

    modport source (output valid, output pixel_color, output pixel_brightness,
                    output refresh, input ready);
    modport sink   (input valid, input pixel_color, input pixel_brightness,
                    input refresh, output ready);
endinterface

interface les_cfg_if;
    logic        valid;
    logic        ready;
    logic [les_pkg::CFG_INDEX_W-1:0] index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/les_step.sv
// ----------------------------------------------------------------------------
// les_step
// one update of the effect state: next state and pixel result
// ----------------------------------------------------------------------------
module les_step (
    input  les_pkg::les_state_t  st,
    input  logic [23:0]          effect_color,
    input  logic [7:0]           blink_limit,
    input  logic [31:0]          now_ms,
    output les_pkg::les_state_t  st_next,
    output les_pkg::les_result_t res
);

    logic [31:0] elapsed;
    logic [7:0]  done_inc;
    logic [6:0]  level_step;

    assign elapsed  = now_ms - st.last_step_time;
    assign done_inc = st.blinks_done + 8'd1;

    // one ramp step along the triangle
    always_comb
    begin
        if (st.ramp_rising)
        begin
            level_step = (st.ramp_level < les_pkg::RAMP_TOP) ? st.ramp_level + 7'd1
                                                             : st.ramp_level;
        end
        else
        begin
            level_step = (st.ramp_level != 7'd0) ? st.ramp_level - 7'd1 : st.ramp_level;
        end
    end

    always_comb
    begin
        st_next     = st;
        res.refresh = 1'b0;
        case (st.mode)
            les_pkg::MODE_OFF:
            begin
                st_next.color_now = 24'd0;
                res.refresh       = 1'b1;
            end
            les_pkg::MODE_STATIC:
            begin
                st_next.color_now = effect_color;
                res.refresh       = 1'b1;
            end
            les_pkg::MODE_BLINK:
            begin
                if (elapsed >= les_pkg::BLINK_PERIOD_MS)
                begin
                    st_next.last_step_time = now_ms;
                    st_next.blink_on       = !st.blink_on;
                    st_next.color_now      = st.blink_on ? 24'd0 : effect_color;
                    res.refresh            = 1'b1;
                    // end of an on phase
                    if (st.blink_on)
                    begin
                        st_next.blinks_done = done_inc;
                        if (blink_limit != 8'd0 && done_inc >= blink_limit)
                        begin
                            st_next.mode        = les_pkg::MODE_BREATHE;
                            st_next.blinks_done = 8'd0;
                        end
                    end
                end
            end
            default:
            begin
                if (elapsed >= les_pkg::BREATHE_PERIOD_MS)
                begin
                    st_next.last_step_time = now_ms;
                    st_next.ramp_level     = level_step;
                    st_next.ramp_rising    = st.ramp_rising ? (level_step < les_pkg::RAMP_TOP)
                                                            : (level_step == 7'd0);
                    st_next.brightness_now = {1'b0, level_step};
                    st_next.color_now      = effect_color;
                    res.refresh            = 1'b1;
                end
            end
        endcase
        res.color      = st_next.color_now;
        res.brightness = st_next.brightness_now;
    end

endmodule

// File: design/led_effect_sequencer.sv
// ----------------------------------------------------------------------------
// led_effect_sequencer
// one-pixel rgb effect driver: off, static, blink and breathe
// ----------------------------------------------------------------------------
//
// channel | dir | payload                                  | moves when
// --------+-----+------------------------------------------+------------------
// upd     | in  | now_ms                                   | valid && ready
// pix     | out | pixel_color, pixel_brightness, refresh   | valid && ready
// cfg     | in  | index, data                              | valid && ready
//
// one update request per cycle while the result side is not stalled; a request
// passes the input register, then the state update into the result register
// the state update itself is a single 32-bit subtract and compare per request
// reset (rst_n low, asynchronous) clears both stages and loads the effect state
// a stalled result holds the pipeline; the input register still takes a request
// while it is empty or its request moves into the result register in that cycle
// register writes are taken at once, cfg.ready is always high
//
module led_effect_sequencer (
    input  logic             clk,
    input  logic             rst_n,
    les_update_if.sink       upd,
    les_pixel_if.source      pix,
    les_cfg_if.sink          cfg
);

    // configuration registers
    les_pkg::les_mode_t effect_mode_reg, effect_mode_next;
    logic [23:0]        effect_color_reg, effect_color_next;
    logic [7:0]         blink_limit_reg, blink_limit_next;
    logic [7:0]         manual_brightness_reg, manual_brightness_next;

    // effect state
    les_pkg::les_state_t state_reg, state_next;
    les_pkg::les_state_t step_state;
    les_pkg::les_result_t step_res;

    // input stage
    logic        in_valid_reg;
    logic [31:0] now_ms_reg;

    // result stage
    logic        out_valid_reg;
    les_pkg::les_result_t out_reg;

    logic advance;
    logic cfg_fire;
    logic restart;

    // request moves from input register to result register
    assign advance   = in_valid_reg && (!out_valid_reg || pix.ready);
    assign upd.ready = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;

    assign pix.valid            = out_valid_reg;
    assign pix.pixel_color      = out_reg.color;
    assign pix.pixel_brightness = out_reg.brightness;
    assign pix.refresh          = out_reg.refresh;

    les_step u_step (
        .st           (state_reg),
        .effect_color (effect_color_reg),
        .blink_limit  (blink_limit_reg),
        .now_ms       (now_ms_reg),
        .st_next      (step_state),
        .res          (step_res)
    );

    // register writes and state update
    always_comb
    begin
        effect_mode_next       = effect_mode_reg;
        effect_color_next      = effect_color_reg;
        blink_limit_next       = blink_limit_reg;
        manual_brightness_next = manual_brightness_reg;
        state_next             = advance ? step_state : state_reg;
        restart                = 1'b0;
        if (cfg_fire)
        begin
            case (cfg.index)
                les_pkg::REG_EFFECT_MODE:
                begin
                    effect_mode_next = les_pkg::les_mode_t'(cfg.data[1:0]);
                    restart          = 1'b1;
                end
                les_pkg::REG_EFFECT_COLOR:
                begin
                    effect_color_next = cfg.data[23:0];
                    restart           = 1'b1;
                end
                les_pkg::REG_BLINK_LIMIT:
                begin
                    blink_limit_next = cfg.data[7:0];
                    restart          = 1'b1;
                end
                les_pkg::REG_MANUAL_BRIGHTNESS:
                begin
                    manual_brightness_next    = cfg.data[7:0];
                    state_next.brightness_now = cfg.data[7:0];
                end
                default:
                begin
                    // unknown index, write dropped
                end
            endcase
        end
        // restart keeps timing, brightness and shown colour
        if (restart)
        begin
            state_next.mode        = effect_mode_next;
            state_next.blink_on    = 1'b0;
            state_next.blinks_done = 8'd0;
            state_next.ramp_level  = 7'd0;
            state_next.ramp_rising = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            effect_mode_reg       <= les_pkg::MODE_OFF;
            effect_color_reg      <= 24'd0;
            blink_limit_reg       <= 8'd0;
            manual_brightness_reg <= les_pkg::BRIGHTNESS_AT_RESET;
            state_reg.mode           <= les_pkg::MODE_OFF;
            state_reg.last_step_time <= 32'd0;
            state_reg.blink_on       <= 1'b0;
            state_reg.blinks_done    <= 8'd0;
            state_reg.ramp_level     <= 7'd0;
            state_reg.ramp_rising    <= 1'b1;
            state_reg.brightness_now <= les_pkg::BRIGHTNESS_AT_RESET;
            state_reg.color_now      <= 24'd0;
        end
        else
        begin
            effect_mode_reg       <= effect_mode_next;
            effect_color_reg      <= effect_color_next;
            blink_limit_reg       <= blink_limit_next;
            manual_brightness_reg <= manual_brightness_next;
            state_reg             <= state_next;
        end
    end

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd.ready)
            begin
                in_valid_reg <= upd.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pix.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (upd.valid && upd.ready)
        begin
            now_ms_reg <= upd.now_ms;
        end
        if (advance)
        begin
            out_reg <= step_res;
        end
    end

endmodule

// File: design/les_checker.sv
// ----------------------------------------------------------------------------
// les_checker
// port-level checks for the led effect sequencer, bound to the top level
// ----------------------------------------------------------------------------
module les_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        upd_valid,
    input logic        upd_ready,
    input logic        pix_valid,
    input logic        pix_ready,
    input logic [23:0] pix_color,
    input logic [7:0]  pix_brightness,
    input logic        pix_refresh
);

    logic [1:0]  pending_reg;
    logic [23:0] last_color_reg;
    logic        seen_reg;
    logic        upd_fire;
    logic        pix_fire;

    assign upd_fire = upd_valid && upd_ready;
    assign pix_fire = pix_valid && pix_ready;

    // requests accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            seen_reg    <= 1'b0;
        end
        else
        begin
            pending_reg <= pending_reg + {1'b0, upd_fire} - {1'b0, pix_fire};
            if (pix_fire)
            begin
                seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            last_color_reg <= pix_color;
        end
    end

    // no result without an outstanding request
    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pending_reg != 2'd0)
        else $error("result offered with no request outstanding");

    // no new frame means the shown colour is unchanged
    a_hold_color: assert property (@(posedge clk) disable iff (!rst_n)
        pix_fire && !pix_refresh && seen_reg |-> pix_color == last_color_reg)
        else $error("colour changed without refresh");

    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> $stable(pix_color) && $stable(pix_brightness)
                                    && $stable(pix_refresh))
        else $error("result payload changed while stalled");

endmodule

bind led_effect_sequencer les_checker u_les_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd_valid      (upd.valid),
    .upd_ready      (upd.ready),
    .pix_valid      (pix.valid),
    .pix_ready      (pix.ready),
    .pix_color      (pix.pixel_color),
    .pix_brightness (pix.pixel_brightness),
    .pix_refresh    (pix.refresh)
);

// File: tb/tb_led_effect_sequencer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_effect_sequencer
// self-checking bench for the one-pixel effect driver: update requests with
// millisecond stamps go in, every frame that comes out is compared with an
// in-bench model of off, static, blink and breathe. register writes happen
// only while the block is drained, and both channels stall at random
// ----------------------------------------------------------------------------
module tb_led_effect_sequencer;

    // expected pixel frame, one per accepted update request
    typedef struct packed {
        logic [23:0] color;
        logic [7:0]  brightness;
        logic        refresh;
    } pixel_frame_t;

    logic clk;
    logic rst_n;

    les_update_if upd_ch ();
    les_pixel_if  pix_ch ();
    les_cfg_if    cfg_ch ();

    led_effect_sequencer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd_ch),
        .pix   (pix_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // model registers and effect state
    // ------------------------------------------------------------------
    les_pkg::les_mode_t reg_mode;
    logic [23:0] reg_color;
    logic [7:0]  reg_limit;
    logic [7:0]  reg_bright;

    les_pkg::les_mode_t fx_mode;
    logic [31:0] fx_last_step;
    logic        fx_blink_on;
    logic [7:0]  fx_blinks;
    logic [6:0]  fx_ramp;
    logic        fx_rising;
    logic [7:0]  fx_bright;
    logic [23:0] fx_color;

    pixel_frame_t pending_frames[$];

    logic [31:0] clock_ms;
    int updates_sent;
    int frames_checked;
    int refresh_frames;
    int mismatches;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_request;

    // ------------------------------------------------------------------
    // clock, runaway guard
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("timeout at %0t, %0d frames still pending", $time, pending_frames.size());
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic void reset_model();
        reg_mode     = les_pkg::MODE_OFF;
        reg_color    = '0;
        reg_limit    = '0;
        reg_bright   = les_pkg::BRIGHTNESS_AT_RESET;
        fx_mode      = les_pkg::MODE_OFF;
        fx_last_step = '0;
        fx_blink_on  = 1'b0;
        fx_blinks    = '0;
        fx_ramp      = '0;
        fx_rising    = 1'b1;
        fx_bright    = les_pkg::BRIGHTNESS_AT_RESET;
        fx_color     = '0;
    endfunction

    // writing any effect register starts the effect over;
    // time stamp, brightness and shown colour survive
    function automatic void restart_effect();
        fx_mode     = reg_mode;
        fx_blink_on = 1'b0;
        fx_blinks   = '0;
        fx_ramp     = '0;
        fx_rising   = 1'b1;
    endfunction

    function automatic void apply_reg_write(input logic [7:0] idx, input logic [31:0] val);
        case (idx)
            les_pkg::REG_EFFECT_MODE:
            begin
                reg_mode = les_pkg::les_mode_t'(val[1:0]);
                restart_effect();
            end
            les_pkg::REG_EFFECT_COLOR:
            begin
                reg_color = val[23:0];
                restart_effect();
            end
            les_pkg::REG_BLINK_LIMIT:
            begin
                reg_limit = val[7:0];
                restart_effect();
            end
            les_pkg::REG_MANUAL_BRIGHTNESS:
            begin
                reg_bright = val[7:0];
                fx_bright  = val[7:0];
            end
            default: ;  // unknown index: nothing changes
        endcase
    endfunction

    // one update call: advance the effect and return the frame it shows
    function automatic pixel_frame_t advance_effect(input logic [31:0] now);
        logic [31:0]  elapsed;
        pixel_frame_t frame;
        elapsed       = now - fx_last_step;   // wraps modulo 2^32
        frame.refresh = 1'b0;
        case (fx_mode)
            les_pkg::MODE_OFF:
            begin
                fx_color      = '0;
                frame.refresh = 1'b1;
            end
            les_pkg::MODE_STATIC:
            begin
                fx_color      = reg_color;
                frame.refresh = 1'b1;
            end
            les_pkg::MODE_BLINK:
            begin
                if (elapsed >= les_pkg::BLINK_PERIOD_MS)
                begin
                    fx_last_step  = now;
                    fx_blink_on   = ~fx_blink_on;
                    fx_color      = fx_blink_on ? reg_color : 24'd0;
                    frame.refresh = 1'b1;
                    // count off phases, hand over to breathe at the limit
                    if (!fx_blink_on)
                    begin
                        fx_blinks = fx_blinks + 8'd1;
                        if (reg_limit != 8'd0 && fx_blinks >= reg_limit)
                        begin
                            fx_mode   = les_pkg::MODE_BREATHE;
                            fx_blinks = '0;
                        end
                    end
                end
            end
            default:
            begin
                if (elapsed >= les_pkg::BREATHE_PERIOD_MS)
                begin
                    fx_last_step = now;
                    // triangle between 0 and the ramp top
                    if (fx_rising)
                    begin
                        if (fx_ramp < les_pkg::RAMP_TOP)
                            fx_ramp = fx_ramp + 7'd1;
                        if (fx_ramp >= les_pkg::RAMP_TOP)
                            fx_rising = 1'b0;
                    end
                    else
                    begin
                        if (fx_ramp > 7'd0)
                            fx_ramp = fx_ramp - 7'd1;
                        if (fx_ramp == 7'd0)
                            fx_rising = 1'b1;
                    end
                    fx_bright     = {1'b0, fx_ramp};
                    fx_color      = reg_color;
                    frame.refresh = 1'b1;
                end
            end
        endcase
        frame.color      = fx_color;
        frame.brightness = fx_bright;
        return frame;
    endfunction

    // ------------------------------------------------------------------
    // pixel side: random stalls, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left    = 0;
        pix_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                pix_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                pix_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // every accepted frame is checked against the oldest expectation
    always @(posedge clk)
    begin : check_frame
        pixel_frame_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected frame color %06h brightness %0d refresh %0b",
                         $time, pix_ch.pixel_color, pix_ch.pixel_brightness, pix_ch.refresh);
                mismatches++;
            end
            else
            begin
                want = pending_frames.pop_front();
                frames_checked++;
                if (pix_ch.refresh)
                    refresh_frames++;
                if (pix_ch.pixel_color !== want.color)
                begin
                    $display("%0t: pixel_color expected %06h actual %06h",
                             $time, want.color, pix_ch.pixel_color);
                    mismatches++;
                end
                if (pix_ch.pixel_brightness !== want.brightness)
                begin
                    $display("%0t: pixel_brightness expected %0d actual %0d",
                             $time, want.brightness, pix_ch.pixel_brightness);
                    mismatches++;
                end
                if (pix_ch.refresh !== want.refresh)
                begin
                    $display("%0t: refresh expected %0b actual %0b",
                             $time, want.refresh, pix_ch.refresh);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request drivers
    // ------------------------------------------------------------------

    // offer one update request; valid stays high into the next one
    // unless a random gap is taken
    task automatic send_update(input logic [31:0] stamp);
        @(negedge clk);
        if ($urandom_range(99) < src_idle_pct)
        begin
            upd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        upd_ch.valid  <= 1'b1;
        upd_ch.now_ms <= stamp;
        do
            @(posedge clk);
        while (!upd_ch.ready);
        pending_frames.push_back(advance_effect(stamp));
        updates_sent++;
    endtask

    task automatic tick(input logic [31:0] delta_ms);
        clock_ms = clock_ms + delta_ms;
        send_update(clock_ms);
    endtask

    // stop offering, let every frame come back, then a few spare cycles
    task automatic drain_pixels();
        @(negedge clk);
        upd_ch.valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        apply_reg_write(idx, val);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // off after reset: cleared pixel at the reset brightness
    task automatic test_reset_defaults();
        send_update(32'd0);
        tick(32'd1);
        tick(32'd500);
    endtask

    // static colour at both colour extremes and both brightness extremes
    task automatic test_static_extremes();
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_STATIC));
        write_reg(les_pkg::REG_EFFECT_COLOR, 32'hFFFF_FFFF);
        write_reg(les_pkg::REG_MANUAL_BRIGHTNESS, 32'd255);
        tick(32'd3);
        tick(32'd0);
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_COLOR, 32'd0);
        write_reg(les_pkg::REG_MANUAL_BRIGHTNESS, 32'd0);
        tick(32'd7);
        tick(32'd250);
    endtask

    // blink around the 100 ms edge until the limit hands over to breathe
    task automatic test_blink_to_breathe();
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_COLOR, 32'h00A5_5AC3);
        write_reg(les_pkg::REG_BLINK_LIMIT, 32'd2);
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_BLINK));
        clock_ms = fx_last_step;
        tick(32'd99);
        tick(32'd1);
        tick(32'd100);
        tick(32'd100);
        tick(32'd100);
        tick(32'd20);
        tick(32'd19);
        tick(32'd1);
    endtask

    // a few breathe steps, then static and blink keep the last brightness
    task automatic test_breathe_then_static();
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_BREATHE));
        tick(32'd20);
        tick(32'd25);
        tick(32'd20);
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_STATIC));
        tick(32'd5);
        drain_pixels();
        write_reg(les_pkg::REG_BLINK_LIMIT, 32'd0);
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_BLINK));
        tick(32'd150);
        tick(32'd100);
    endtask

    // writes to indexes past the last register must change nothing
    task automatic test_unknown_index();
        drain_pixels();
        write_reg(8'd4, 32'hFFFF_FFFF);
        write_reg(8'd255, 32'h5555_5555);
        tick(32'd100);
        tick(32'd100);
    endtask

    // hold the pixel side off while requests keep coming, so the
    // pipeline fills and back-pressures the update side
    task automatic test_pixel_hold_off();
        drain_pixels();
        write_reg(les_pkg::REG_EFFECT_MODE, 32'(les_pkg::MODE_BREATHE));
        src_idle_pct = 0;
        hold_request = 60;
        repeat (24) tick($urandom_range(15, 30));
        src_idle_pct = 26;
    endtask

    // one effect setting, then a run of time-stamped updates
    task automatic run_effect_phase(input int base_items);
        int          n_items;
        int          roll;
        logic [31:0] val;
        drain_pixels();
        if ($urandom_range(7) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);  // cross the wrap
        if ($urandom_range(1) == 0)
        begin
            roll = $urandom_range(5);
            val  = (roll == 0) ? 32'd0 : (roll == 1) ? 32'hFFFF_FFFF : $urandom;
            write_reg(les_pkg::REG_EFFECT_COLOR, val);
        end
        if ($urandom_range(1) == 0)
        begin
            val  = $urandom;
            roll = $urandom_range(5);
            val[7:0] = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 :
                       (roll == 2) ? 8'd1 : 8'($urandom_range(2, 6));
            write_reg(les_pkg::REG_BLINK_LIMIT, val);
        end
        if ($urandom_range(2) == 0)
        begin
            val  = $urandom;
            roll = $urandom_range(3);
            if (roll == 0)
                val[7:0] = 8'd0;
            else if (roll == 1)
                val[7:0] = 8'd255;
            write_reg(les_pkg::REG_MANUAL_BRIGHTNESS, val);
        end
        if ($urandom_range(4) == 0)
            write_reg(8'($urandom_range(4, 255)), $urandom);
        write_reg(les_pkg::REG_EFFECT_MODE, $urandom);

        n_items = base_items;
        // now and then a breathe run long enough to turn at the top
        if (reg_mode == les_pkg::MODE_BREATHE && $urandom_range(2) == 0)
            n_items = 130;
        clock_ms = fx_last_step + $urandom_range(0, 30);
        repeat (n_items)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                clock_ms = $urandom;                          // arbitrary jump
            else if (roll < 5)
                clock_ms = clock_ms - $urandom_range(1, 50);  // time going back
            else if (reg_mode == les_pkg::MODE_BLINK)
                clock_ms = clock_ms + $urandom_range(15, 110);
            else if (reg_mode == les_pkg::MODE_BREATHE)
                clock_ms = clock_ms + $urandom_range(12, 30);
            else
                clock_ms = clock_ms + $urandom_range(0, 200);
            send_update(clock_ms);
        end
    endtask

    // both sides without any idling for a long stretch
    task automatic test_no_gaps();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_effect_phase(60);
        src_idle_pct = 26;
        snk_idle_pct = 26;
    endtask

    task automatic test_random_effects();
        while (updates_sent < 520)
            run_effect_phase($urandom_range(8, 40));
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        upd_ch.valid   = 1'b0;
        upd_ch.now_ms  = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        clock_ms       = '0;
        updates_sent   = 0;
        frames_checked = 0;
        refresh_frames = 0;
        mismatches     = 0;
        src_idle_pct   = 26;
        snk_idle_pct   = 26;
        hold_request   = 0;
        reset_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_static_extremes();
        test_blink_to_breathe();
        test_breathe_then_static();
        test_unknown_index();
        test_pixel_hold_off();
        test_no_gaps();
        test_random_effects();

        drain_pixels();
        repeat (10) @(posedge clk);
        if (pending_frames.size() != 0)
        begin
            $display("%0d frames never arrived", pending_frames.size());
            mismatches++;
        end
        $display("covered %0d update requests, %0d frames checked (%0d with refresh)",
                 updates_sent, frames_checked, refresh_frames);
        $display("effects off, static, blink and breathe, register extremes, %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: files.f
design/les_pkg.sv
design/les_ifs.sv
design/les_step.sv
design/led_effect_sequencer.sv
design/les_checker.sv
tb/tb_led_effect_sequencer.sv
